>>> hw/rtl/i2c_master_transaction_sequencer_assert.svh
// assertion macros for the i2c master transaction sequencer checker
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define I2CMTS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define I2CMTS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/i2cmts_pkg.sv
// types and constants shared by the i2c master transaction sequencer
package i2cmts_pkg;

	localparam int POS_W = 10;
	localparam logic [POS_W-1:0] POS_MINUS_TWO = 10'h3FE;

	// command codes
	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_START  = 2'd1;
	localparam logic [1:0] CMD_STATUS = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_SLAVE_ADDRESS    = 2'd0;
	localparam logic [1:0] CFG_TARGET_ADDR_HIGH = 2'd1;
	localparam logic [1:0] CFG_TARGET_ADDR_LOW  = 2'd2;
	localparam logic [1:0] CFG_MESSAGE_LENGTH   = 2'd3;

	// bus status codes
	localparam logic [7:0] ST_START       = 8'h08;
	localparam logic [7:0] ST_REP_START   = 8'h10;
	localparam logic [7:0] ST_TX_ADDR_ACK = 8'h18;
	localparam logic [7:0] ST_DATA_TX     = 8'h28;
	localparam logic [7:0] ST_RX_ADDR_ACK = 8'h40;
	localparam logic [7:0] ST_DATA_RX     = 8'h50;
	localparam logic [7:0] ST_LAST_RX     = 8'h58;

	typedef enum logic [2:0] {
		PH_START   = 3'd0,
		PH_ADDR_WR = 3'd1,
		PH_ADDR_RD = 3'd2,
		PH_DATA_TX = 3'd3,
		PH_DATA_RX = 3'd4
	} phase_t;

	typedef enum logic {
		SEQ_IDLE = 1'b0,
		SEQ_EXEC = 1'b1
	} seq_state_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] load_index;
		logic [7:0] load_byte;
		logic [7:0] status_code;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] slave_address;
		logic [7:0] target_addr_high;
		logic [7:0] target_addr_low;
		logic [8:0] message_length;
	} cfg_t;

	typedef struct packed {
		logic       send_valid;
		logic [7:0] send_byte;
		logic       set_start;
		logic       clear_start;
		logic       set_stop;
		logic       set_ack;
		logic       clear_ack;
		logic       recv_valid;
		logic [7:0] recv_index;
		logic       done_res;
		logic       failed;
	} rsp_t;

	typedef struct packed {
		phase_t           phase;
		logic [POS_W-1:0] pos;
		logic             mem_we;
	} upd_t;

endpackage

>>> hw/rtl/i2cmts_if.sv
// valid/ready channel interfaces: item input, result output, register writes
interface i2cmts_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [7:0] load_index;
	logic [7:0] load_byte;
	logic [7:0] status_code;
	logic [7:0] rx_byte;

	modport source (output valid, cmd, load_index, load_byte, status_code, rx_byte,
		input ready);
	modport sink (input valid, cmd, load_index, load_byte, status_code, rx_byte,
		output ready);
endinterface

interface i2cmts_rsp_if;
	logic       valid;
	logic       ready;
	logic       send_valid;
	logic [7:0] send_byte;
	logic       set_start;
	logic       clear_start;
	logic       set_stop;
	logic       set_ack;
	logic       clear_ack;
	logic       recv_valid;
	logic [7:0] recv_index;
	logic       done_res;
	logic       failed;

	modport source (output valid, send_valid, send_byte, set_start, clear_start, set_stop,
		set_ack, clear_ack, recv_valid, recv_index, done_res, failed, input ready);
	modport sink (input valid, send_valid, send_byte, set_start, clear_start, set_stop,
		set_ack, clear_ack, recv_valid, recv_index, done_res, failed, output ready);
endinterface

interface i2cmts_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [8:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/i2cmts_ram.sv
// generic single-port-write, registered-read ram
module i2cmts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/i2cmts_action.sv
// per-event action decode: result word, next phase and position, buffer write
module i2cmts_action #(
	parameter int BUFFER_DEPTH = 256
) (
	input  i2cmts_pkg::item_t                          item,
	input  i2cmts_pkg::phase_t                         phase,
	input  logic [i2cmts_pkg::POS_W-1:0]               pos,
	input  i2cmts_pkg::cfg_t                           cfg,
	input  logic [7:0]                                 rdata,
	output i2cmts_pkg::rsp_t                           res,
	output i2cmts_pkg::upd_t                           upd,
	output logic [(BUFFER_DEPTH > 1 ? $clog2(BUFFER_DEPTH) : 1)-1:0] waddr,
	output logic [7:0]                                 wdata
);

	localparam int AW = BUFFER_DEPTH > 1 ? $clog2(BUFFER_DEPTH) : 1;

	logic [i2cmts_pkg::POS_W-1:0] pnext;
	logic [8:0]                   eff_len;
	logic signed [10:0]           left;
	logic                         pos_in_buf;
	logic                         pnext_in_buf;
	logic                         load_in_buf;
	logic                         pnext_below_len;
	logic                         fin;
	logic                         fin_fail;

	assign pnext = pos + 10'd1;
	assign eff_len = (cfg.message_length == 9'd0) ? 9'd1 : cfg.message_length;
	// bytes still to read after this one, signed
	assign left = $signed({2'b00, eff_len}) - $signed({pnext[9], pnext});
	assign pos_in_buf = !pos[9] && (32'(pos[8:0]) < BUFFER_DEPTH);
	assign pnext_in_buf = !pnext[9] && (32'(pnext[8:0]) < BUFFER_DEPTH);
	assign load_in_buf = 32'(item.load_index) < BUFFER_DEPTH;
	assign pnext_below_len = {1'b0, pnext[8:0]} < {1'b0, cfg.message_length};

	always_comb begin
		res = '0;
		upd.phase = phase;
		upd.pos = pos;
		upd.mem_we = 1'b0;
		waddr = AW'(item.load_index);
		wdata = item.load_byte;
		fin = 1'b0;
		fin_fail = 1'b0;
		unique case (item.cmd)
			i2cmts_pkg::CMD_LOAD: begin
				upd.mem_we = load_in_buf;
			end
			i2cmts_pkg::CMD_START: begin
				res.set_start = 1'b1;
				upd.phase = i2cmts_pkg::PH_START;
				upd.pos = i2cmts_pkg::POS_MINUS_TWO;
			end
			i2cmts_pkg::CMD_STATUS: begin
				case (phase)
					i2cmts_pkg::PH_START: begin
						res.clear_start = 1'b1;
						if (item.status_code == i2cmts_pkg::ST_START ||
							item.status_code == i2cmts_pkg::ST_REP_START) begin
							res.send_valid = 1'b1;
							res.send_byte = cfg.slave_address;
							if (cfg.slave_address[0]) begin
								upd.phase = i2cmts_pkg::PH_ADDR_RD;
								upd.pos = '0;
							end else begin
								upd.phase = i2cmts_pkg::PH_ADDR_WR;
								upd.pos = i2cmts_pkg::POS_MINUS_TWO;
							end
						end else begin
							fin = 1'b1;
							fin_fail = 1'b1;
						end
					end
					i2cmts_pkg::PH_ADDR_WR: begin
						if (item.status_code == i2cmts_pkg::ST_TX_ADDR_ACK) begin
							res.send_valid = 1'b1;
							res.send_byte = cfg.target_addr_high;
							upd.phase = i2cmts_pkg::PH_DATA_TX;
						end else begin
							fin = 1'b1;
							fin_fail = 1'b1;
						end
					end
					i2cmts_pkg::PH_ADDR_RD: begin
						if (item.status_code == i2cmts_pkg::ST_RX_ADDR_ACK) begin
							upd.phase = i2cmts_pkg::PH_DATA_RX;
							res.set_ack = cfg.message_length > 9'd1;
						end else begin
							fin = 1'b1;
							fin_fail = 1'b1;
						end
					end
					i2cmts_pkg::PH_DATA_RX: begin
						if (item.status_code == i2cmts_pkg::ST_DATA_RX ||
							item.status_code == i2cmts_pkg::ST_LAST_RX) begin
							if (pos_in_buf) begin
								upd.mem_we = 1'b1;
								waddr = AW'(pos[8:0]);
								wdata = item.rx_byte;
								res.recv_valid = 1'b1;
								res.recv_index = pos[7:0];
							end
							upd.pos = pnext;
							if (left == 11'sd0) begin
								fin = 1'b1;
							end else if (left <= 11'sd1) begin
								res.clear_ack = 1'b1;
							end
						end else begin
							fin = 1'b1;
							fin_fail = 1'b1;
						end
					end
					i2cmts_pkg::PH_DATA_TX: begin
						if (item.status_code == i2cmts_pkg::ST_DATA_TX) begin
							upd.pos = pnext;
							if (pnext[9]) begin
								res.send_valid = 1'b1;
								res.send_byte = cfg.target_addr_low;
							end else if (pnext_below_len) begin
								res.send_valid = 1'b1;
								res.send_byte = pnext_in_buf ? rdata : 8'h00;
							end else begin
								fin = 1'b1;
							end
						end else begin
							fin = 1'b1;
							fin_fail = 1'b1;
						end
					end
					default: begin
						upd.phase = i2cmts_pkg::PH_START;
					end
				endcase
			end
			default: begin
			end
		endcase
		if (fin) begin
			res.clear_ack = 1'b1;
			res.set_stop = 1'b1;
			res.done_res = 1'b1;
			res.failed = fin_fail;
			upd.phase = i2cmts_pkg::PH_START;
		end
	end

endmodule

>>> hw/rtl/i2c_master_transaction_sequencer.sv
// the item is registered at its transfer and the result at its commit; a new item is taken
// only once the last one has committed, since the buffer ram's registered read splits the work:
// the read is issued at the transfer edge and the action is decoded from the read data in exec
// a waiting result holds the commit, and with it the next transfer
// reset: phase start sent, position minus two, registers 0, buffer undefined
module i2c_master_transaction_sequencer #(
	parameter int BUFFER_DEPTH = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	i2cmts_req_if.sink         req,
	i2cmts_rsp_if.source       rsp,
	i2cmts_cfg_if.sink         cfg
);

	localparam int AW = BUFFER_DEPTH > 1 ? $clog2(BUFFER_DEPTH) : 1;

	i2cmts_pkg::seq_state_t        state_q, state_d;
	i2cmts_pkg::phase_t            phase_q;
	logic [i2cmts_pkg::POS_W-1:0]  pos_q;
	logic [i2cmts_pkg::POS_W-1:0]  pos_inc;
	i2cmts_pkg::cfg_t              cfg_q;
	i2cmts_pkg::item_t             item_q;
	i2cmts_pkg::rsp_t              rsp_q;
	logic                          rsp_valid_q;
	i2cmts_pkg::rsp_t              res;
	i2cmts_pkg::upd_t              upd;
	logic [AW-1:0]                 waddr;
	logic [7:0]                    wdata;
	logic [7:0]                    rdata;
	logic                          accept;
	logic                          commit;

	assign accept = req.valid && req.ready;
	assign pos_inc = pos_q + 10'd1;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			i2cmts_pkg::SEQ_IDLE: begin
				if (req.valid) begin
					state_d = i2cmts_pkg::SEQ_EXEC;
				end
			end
			i2cmts_pkg::SEQ_EXEC: begin
				if (!rsp_valid_q || rsp.ready) begin
					state_d = i2cmts_pkg::SEQ_IDLE;
				end
			end
			default: state_d = i2cmts_pkg::SEQ_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req.ready = 1'b0;
		commit = 1'b0;
		unique case (state_q)
			i2cmts_pkg::SEQ_IDLE: req.ready = 1'b1;
			i2cmts_pkg::SEQ_EXEC: commit = !rsp_valid_q || rsp.ready;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= i2cmts_pkg::SEQ_IDLE;
			phase_q <= i2cmts_pkg::PH_START;
			pos_q <= i2cmts_pkg::POS_MINUS_TWO;
			rsp_valid_q <= 1'b0;
			cfg_q <= '0;
		end else begin
			state_q <= state_d;
			if (commit) begin
				phase_q <= upd.phase;
				pos_q <= upd.pos;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg.valid) begin
				unique case (cfg.index)
					i2cmts_pkg::CFG_SLAVE_ADDRESS:    cfg_q.slave_address <= cfg.data[7:0];
					i2cmts_pkg::CFG_TARGET_ADDR_HIGH: cfg_q.target_addr_high <= cfg.data[7:0];
					i2cmts_pkg::CFG_TARGET_ADDR_LOW:  cfg_q.target_addr_low <= cfg.data[7:0];
					i2cmts_pkg::CFG_MESSAGE_LENGTH:   cfg_q.message_length <= cfg.data;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= '{cmd: req.cmd, load_index: req.load_index, load_byte: req.load_byte,
				status_code: req.status_code, rx_byte: req.rx_byte};
		end
		if (commit) begin
			rsp_q <= res;
		end
	end

	assign cfg.ready = 1'b1;

	// ram writes happen only at commit and reads only at transfer, so the two never meet
	i2cmts_ram #(
		.WIDTH (8),
		.DEPTH (BUFFER_DEPTH)
	) u_buf (
		.clk   (clk),
		.we    (commit && upd.mem_we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (accept),
		.raddr (AW'(pos_inc[8:0])),
		.rdata (rdata)
	);

	i2cmts_action #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_action (
		.item  (item_q),
		.phase (phase_q),
		.pos   (pos_q),
		.cfg   (cfg_q),
		.rdata (rdata),
		.res   (res),
		.upd   (upd),
		.waddr (waddr),
		.wdata (wdata)
	);

	assign rsp.valid = rsp_valid_q;
	assign rsp.send_valid = rsp_q.send_valid;
	assign rsp.send_byte = rsp_q.send_byte;
	assign rsp.set_start = rsp_q.set_start;
	assign rsp.clear_start = rsp_q.clear_start;
	assign rsp.set_stop = rsp_q.set_stop;
	assign rsp.set_ack = rsp_q.set_ack;
	assign rsp.clear_ack = rsp_q.clear_ack;
	assign rsp.recv_valid = rsp_q.recv_valid;
	assign rsp.recv_index = rsp_q.recv_index;
	assign rsp.done_res = rsp_q.done_res;
	assign rsp.failed = rsp_q.failed;

endmodule

>>> hw/rtl/i2cmts_chk.sv
// port-level checker for the i2c master transaction sequencer, with its bind
`include "i2c_master_transaction_sequencer_assert.svh"

module i2cmts_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic       send_valid,
	input logic [7:0] send_byte,
	input logic       set_start,
	input logic       recv_valid,
	input logic [7:0] recv_index,
	input logic       done_res,
	input logic       failed
);

	`I2CMTS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(send_byte) && $stable(done_res), "result changed while stalled")
	`I2CMTS_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "transfer taken while an item is in work")
	`I2CMTS_ASSERT_SAME(a_fail_done, rsp_valid && failed, done_res, "failed without done")
	`I2CMTS_ASSERT_SAME(a_idle_zero, rsp_valid, (send_valid || send_byte == 8'h00) && (recv_valid || recv_index == 8'h00), "byte or index without its valid")
	`I2CMTS_ASSERT_SAME(a_start_alone, rsp_valid && set_start, !send_valid && !done_res && !recv_valid, "start request mixed with bus action")

endmodule

bind i2c_master_transaction_sequencer i2cmts_chk u_i2cmts_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.send_valid (rsp.send_valid),
	.send_byte  (rsp.send_byte),
	.set_start  (rsp.set_start),
	.recv_valid (rsp.recv_valid),
	.recv_index (rsp.recv_index),
	.done_res   (rsp.done_res),
	.failed     (rsp.failed)
);
